// ===== hw/rtl/i2ctrf_pkg.sv =====
// shared constants, types and helpers for the i2c target register file
`default_nettype none

package i2ctrf_pkg;

  // number of byte entries in the register file
  localparam int REG_BYTES = 16;
  // entry address width
  localparam int ADDR_W = $clog2(REG_BYTES);
  // width of the bus read length, holds 0 to REG_BYTES
  localparam int REM_W = $clog2(REG_BYTES + 1);
  // width used for range compares against REG_BYTES and incoming bytes
  localparam int CMP_W = 10;

  // request kinds
  typedef enum logic [1:0] {
    KIND_BUS_WR   = 2'd0,
    KIND_BUS_RD   = 2'd1,
    KIND_LOCAL_WR = 2'd2,
    KIND_LOCAL_RD = 2'd3
  } kind_t;

  // bus write transfer phase, one-hot
  typedef enum logic [2:0] {
    PH_POINTER = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_DATA    = 3'b100
  } phase_t;

  // access to the register file storage
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // pointer advance with wrap at the end of the file
  function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
    logic [ADDR_W:0] n;
    n = {1'b0, p} + (ADDR_W + 1)'(1);
    return (n == (ADDR_W + 1)'(REG_BYTES)) ? '0 : n[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2ctrf_regmem.sv =====
// byte storage of the register file with one write and one registered read port
`default_nettype none

module i2ctrf_regmem (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire i2ctrf_pkg::mem_req_t          req,
  output logic [7:0]                         rd_data
);

  logic [7:0]                       ram [i2ctrf_pkg::REG_BYTES];
  logic [i2ctrf_pkg::REG_BYTES-1:0] ent_vld_r;
  logic [7:0]                       rd_data_r;
  logic                             rd_hit_r;

  // storage write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      ram[req.wr_addr] <= req.wr_data;
    end
  end

  // written flags, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (req.wr_en) begin
      ent_vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= ram[req.rd_addr];
      rd_hit_r  <= ent_vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : 8'd0;

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_target_register_file_top.sv =====
// top level of the i2c target register file
// Byte register file behind an i2c target, driven one request at a time.
// Input channel (in_valid/in_ready) carries a request: a bus write byte,
// a bus read byte, a local write or a local read, with first/last flags that
// frame a bus write transfer (pointer byte, length byte, then data bytes).
// Result channel (out_valid/out_ready) returns exactly one result per request:
// read_byte and read_valid for reads, receive_done on the last bus write byte.
// A result passes through the read stage, which lines up with the synchronous
// storage read, and then through the output register before it is offered.
// Throughput: one request per cycle while out_ready is high; the storage
// read/write happens in the accept cycle, so pointer and length updates are
// in place for the next request with no interlock.
// When out_ready is low the output register holds its result, the read stage
// behind it holds one more, and in_ready drops until the output drains.
// Reset clears pointer, length, phase and the pipeline; the storage reads as
// all zero right after reset through per-entry written flags, no clearing pass.
`default_nettype none

module i2c_target_register_file_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_kind,
  input  wire logic       in_first,
  input  wire logic       in_last,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [3:0] in_local_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_byte,
  output logic            out_read_valid,
  output logic            out_receive_done
);

  localparam int AW = i2ctrf_pkg::ADDR_W;
  localparam int RW = i2ctrf_pkg::REM_W;
  localparam int CW = i2ctrf_pkg::CMP_W;

  i2ctrf_pkg::phase_t   phase_r, phase_nxt, ph_eff;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  i2ctrf_pkg::mem_req_t req;
  logic [7:0]           mem_rd_data;

  logic                 s1_vld_r, s1_rv_r, s1_done_r;
  logic                 rv_nxt, done_nxt;
  logic                 out_valid_r, out_read_valid_r, out_receive_done_r;
  logic [7:0]           out_read_byte_r;

  logic                 accept, s1_adv, s2_take;
  logic [CW-1:0]        data_w, room_w, limit_w;
  logic                 idx_ok;

  // pipeline flow
  assign s2_take  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_vld_r || s2_take;
  assign in_ready = s1_adv;
  assign accept   = in_valid && in_ready;

  // range helpers
  assign data_w  = CW'(in_data_byte);
  assign limit_w = CW'(i2ctrf_pkg::REG_BYTES);
  assign room_w  = limit_w - CW'(ptr_r);
  assign idx_ok  = CW'(in_local_index) < limit_w;
  assign ph_eff  = in_first ? i2ctrf_pkg::PH_POINTER : phase_r;

  // request decode, state update and storage access
  always_comb begin
    ptr_nxt     = ptr_r;
    rem_nxt     = rem_r;
    phase_nxt   = phase_r;
    rv_nxt      = 1'b0;
    done_nxt    = 1'b0;
    req         = '0;
    req.wr_data = in_data_byte;
    if (accept) begin
      unique case (i2ctrf_pkg::kind_t'(in_kind))
        i2ctrf_pkg::KIND_BUS_WR: begin
          unique case (ph_eff)
            i2ctrf_pkg::PH_POINTER: begin
              ptr_nxt   = (data_w >= limit_w) ? '0 : AW'(in_data_byte);
              phase_nxt = i2ctrf_pkg::PH_LENGTH;
            end
            i2ctrf_pkg::PH_LENGTH: begin
              rem_nxt   = (data_w > room_w) ? RW'(room_w) : RW'(data_w);
              phase_nxt = i2ctrf_pkg::PH_DATA;
            end
            i2ctrf_pkg::PH_DATA: begin
              req.wr_en   = 1'b1;
              req.wr_addr = ptr_r;
              ptr_nxt     = i2ctrf_pkg::next_ptr(ptr_r);
              phase_nxt   = i2ctrf_pkg::PH_DATA;
            end
            default: begin
              phase_nxt = i2ctrf_pkg::PH_POINTER;
            end
          endcase
          if (in_last) begin
            done_nxt  = 1'b1;
            phase_nxt = i2ctrf_pkg::PH_POINTER;
          end
        end
        i2ctrf_pkg::KIND_BUS_RD: begin
          if (rem_r != '0) begin
            req.rd_en   = 1'b1;
            req.rd_addr = ptr_r;
            rv_nxt      = 1'b1;
            rem_nxt     = rem_r - RW'(1);
            ptr_nxt     = i2ctrf_pkg::next_ptr(ptr_r);
          end
        end
        i2ctrf_pkg::KIND_LOCAL_WR: begin
          if (idx_ok) begin
            req.wr_en   = 1'b1;
            req.wr_addr = AW'(in_local_index);
          end
        end
        i2ctrf_pkg::KIND_LOCAL_RD: begin
          if (idx_ok) begin
            req.rd_en   = 1'b1;
            req.rd_addr = AW'(in_local_index);
            rv_nxt      = 1'b1;
          end
        end
        default: begin
          rv_nxt = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2ctrf_pkg::PH_POINTER;
      ptr_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      ptr_r   <= ptr_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // storage
  i2ctrf_regmem u_regmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (mem_rd_data)
  );

  // read stage, lines up with the storage read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rv_r   <= rv_nxt;
      s1_done_r <= done_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_vld_r) begin
      out_read_byte_r    <= s1_rv_r ? mem_rd_data : 8'd0;
      out_read_valid_r   <= s1_rv_r;
      out_receive_done_r <= s1_done_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = out_read_byte_r;
  assign out_read_valid   = out_read_valid_r;
  assign out_receive_done = out_receive_done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/i2ctrf_checker.sv =====
// port-level checks for the i2c target register file, bound to the top level
`default_nettype none

module i2ctrf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_byte,
  input wire logic       out_read_valid,
  input wire logic       out_receive_done
);

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte)
      && $stable(out_read_valid) && $stable(out_receive_done))
    else $error("stalled result changed");

  // a write transfer end never carries read data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_receive_done |-> !out_read_valid)
    else $error("receive_done together with read_valid");

  // no read data means a zero byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_byte == 8'd0)
    else $error("read_byte nonzero without read_valid");

  // nothing is offered right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a result appears only after an accepted request has moved through the read stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!out_valid) && !out_valid && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result without a request");

endmodule

bind i2c_target_register_file_top i2ctrf_checker u_i2ctrf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_read_byte    (out_read_byte),
  .out_read_valid   (out_read_valid),
  .out_receive_done (out_receive_done)
);

`default_nettype wire
